### sv/arpc_pkg.sv
// ----------------------------------------------------------------------------
// ARP cache package
// Transaction payload types, result status codes and sequencer states shared
// by the ARP address cache, its table memory and its port checker.
// ----------------------------------------------------------------------------
package arpc_pkg;

	// Request type codes
	localparam logic REQ_LOOKUP = 1'b0;
	localparam logic REQ_LEARN  = 1'b1;

	// Result status of one transaction
	typedef enum logic [1:0] {
		LS_NONE     = 2'd0,
		LS_UPDATED  = 2'd1,
		LS_INSERTED = 2'd2,
		LS_FULL     = 2'd3
	} status_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// Request transaction
	typedef struct packed {
		logic        req_type;
		logic [31:0] ip_addr;
		logic [47:0] mac_addr;
	} req_t;

	// Response transaction
	typedef struct packed {
		logic        hit;
		logic [47:0] mac_out;
		status_t     learn_status;
	} rsp_t;

	// One table entry
	typedef struct packed {
		logic [31:0] ip;
		logic [47:0] mac;
	} entry_t;

endpackage

### sv/arpc_table.sv
// ----------------------------------------------------------------------------
// ARP cache table memory
// Single write port, single read port with registered read data. Holds the
// protocol and hardware address of every entry.
// ----------------------------------------------------------------------------
module arpc_table
	import arpc_pkg::*;
#(
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output entry_t                   rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  entry_t                   wr_data
);

	entry_t mem [DEPTH];
	entry_t rd_data_q;

	// Write one entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Register read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### sv/arp_address_cache.sv
// ----------------------------------------------------------------------------
// ARP address cache
// Maps IPv4 protocol addresses to Ethernet hardware addresses; answers
// lookups and learns address pairs from replies.
// ----------------------------------------------------------------------------
// A lookup returns the hardware address of the lowest valid entry whose
// protocol address matches. A learn overwrites the hardware address of a
// matching entry, or else fills the next free slot; a learn into a full
// table is dropped and reported as LS_FULL. Entries fill from index 0
// upward and are never removed, so a fill count stands in for valid bits and
// no clearing pass is needed after reset. One transaction is in work at a
// time: the sequencer streams the filled entries through the table memory's
// single read port into one address comparator, one entry per cycle, and
// stops at the first match. The scan ends on a match or once every filled
// entry has been compared. The result is registered only when the output
// register is free, so a response held by rsp_stall keeps req_stall high;
// req_stall is low again in the same cycle as the new response appears.
module arp_address_cache
	import arpc_pkg::*;
#(
	parameter int TABLE_ENTRIES = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	state_t             state_q, state_d;
	req_t               req_q;
	logic [CNT_W-1:0]   scan_idx_q;
	logic [CNT_W-1:0]   fill_q;
	logic               rd_vld_q;
	logic [IDX_W-1:0]   rd_idx_q;
	logic               found_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic [47:0]        mac_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic               req_accept;
	logic               rd_issue;
	logic               cmp_hit;
	logic               scan_end;
	logic               out_free;
	logic               table_full;
	logic               done_fire;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	entry_t             wr_data;
	entry_t             rd_data;
	rsp_t               rsp_d;

	// Table memory
	arpc_table #(
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk     (clk),
		.rd_en   (rd_issue),
		.rd_addr (scan_idx_q[IDX_W-1:0]),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// Shared comparator and scan status
	assign cmp_hit    = rd_vld_q && (rd_data.ip == req_q.ip_addr);
	assign out_free   = !rsp_valid_q || !rsp_stall;
	assign table_full = (fill_q == CNT_W'(TABLE_ENTRIES));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		req_stall  = 1'b1;
		req_accept = 1'b0;
		rd_issue   = 1'b0;
		scan_end   = 1'b0;
		done_fire  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_stall  = 1'b0;
				req_accept = req_valid;
			end
			ST_SCAN: begin
				rd_issue = (scan_idx_q < fill_q);
				scan_end = cmp_hit || (!rd_vld_q && !(scan_idx_q < fill_q));
			end
			ST_DONE: begin
				done_fire = out_free;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	// Table write: update the matching entry or insert at the fill point
	always_comb begin
		wr_en        = done_fire && (req_q.req_type == REQ_LEARN) && (found_q || !table_full);
		wr_addr      = found_q ? hit_idx_q : fill_q[IDX_W-1:0];
		wr_data.ip   = req_q.ip_addr;
		wr_data.mac  = req_q.mac_addr;
	end

	// Build the response
	always_comb begin
		rsp_d.hit          = 1'b0;
		rsp_d.mac_out      = '0;
		rsp_d.learn_status = LS_NONE;
		if (req_q.req_type == REQ_LOOKUP) begin
			if (found_q) begin
				rsp_d.hit     = 1'b1;
				rsp_d.mac_out = mac_q;
			end
		end else if (found_q) begin
			rsp_d.learn_status = LS_UPDATED;
		end else if (!table_full) begin
			rsp_d.learn_status = LS_INSERTED;
		end else begin
			rsp_d.learn_status = LS_FULL;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			scan_idx_q  <= '0;
			rd_vld_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// Restart the scan on a new transaction, advance it while scanning
			if (req_accept) begin
				scan_idx_q <= '0;
				rd_vld_q   <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				rd_vld_q <= rd_issue;
				if (rd_issue) begin
					scan_idx_q <= scan_idx_q + CNT_W'(1);
				end
			end
			// Advance the fill count on insert
			if (done_fire && (req_q.req_type == REQ_LEARN) && !found_q && !table_full) begin
				fill_q <= fill_q + CNT_W'(1);
			end
			// Hold the response until taken
			if (done_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (req_accept) begin
			req_q <= req;
		end
		if (state_q == ST_SCAN) begin
			rd_idx_q <= scan_idx_q[IDX_W-1:0];
		end
		if (scan_end) begin
			found_q   <= cmp_hit;
			hit_idx_q <= rd_idx_q;
			mac_q     <= rd_data.mac;
		end
		if (done_fire) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### sv/arpc_checker.sv
// ----------------------------------------------------------------------------
// ARP cache port checker
// Watches the ports of the ARP address cache and flags responses that break
// the transaction rules or the encoding of the result fields.
// ----------------------------------------------------------------------------
module arpc_checker
	import arpc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// Hold a stalled response
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// Stall requests while a transaction is in work
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted during a scan");

	// Report a hit only for lookups
	a_hit_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.hit |-> rsp.learn_status == LS_NONE)
		else $error("hit reported with a learn status");

	// Drive zero hardware address on a miss
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.hit |-> rsp.mac_out == 48'd0)
		else $error("nonzero address without hit");

endmodule

bind arp_address_cache arpc_checker u_arpc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

### dv/tb_arp_address_cache.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ARP address cache testbench
// Drives lookup and learn requests through the valid/stall request port and
// checks every response against a shadow copy of the cache table kept here.
// The run starts with a directed pass over the address extremes, then goes
// through random phases with and without idling on either side, and one
// phase with a long response hold-off that backs up the request port.
// ----------------------------------------------------------------------------
module tb_arp_address_cache;
	import arpc_pkg::*;

	localparam int TABLE_ENTRIES = 32;
	localparam int POOL_SIZE     = 40;
	localparam int PHASE_ITEMS   = 240;
	localparam int HOLD_CYCLES   = 400;
	localparam int CYCLE_LIMIT   = 600000;

	logic clk;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// Shadow of the cache table
	logic        cache_valid [TABLE_ENTRIES];
	logic [31:0] cache_ip    [TABLE_ENTRIES];
	logic [47:0] cache_mac   [TABLE_ENTRIES];

	req_t        request_q[$];
	rsp_t        answer_q[$];
	logic [31:0] ip_pool[POOL_SIZE];

	int  queued_count   = 0;
	int  accepted_count = 0;
	int  fail_count     = 0;
	int  cycle_count    = 0;
	int  send_idle_pct  = 0;
	int  stall_pct      = 0;
	int  hold_left      = 0;
	bit  hold_armed     = 1'b0;
	bit  hold_started   = 1'b0;
	bit  req_taken      = 1'b0;

	arp_address_cache #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit roll(int pct);
		return $urandom_range(99) < pct;
	endfunction

	function automatic logic [47:0] rand_mac();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[47:0];
	endfunction

	// Work out the response to one request and update the shadow table
	function automatic rsp_t resolve_request(req_t r);
		rsp_t a;
		int   match_slot;
		int   free_slot;
		a.hit          = 1'b0;
		a.mac_out      = '0;
		a.learn_status = LS_NONE;
		match_slot     = -1;
		free_slot      = -1;
		for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
			if (cache_valid[k] && cache_ip[k] == r.ip_addr)
				match_slot = k;
			if (!cache_valid[k])
				free_slot = k;
		end
		if (r.req_type == REQ_LOOKUP) begin
			if (match_slot >= 0) begin
				a.hit     = 1'b1;
				a.mac_out = cache_mac[match_slot];
			end
		end else if (match_slot >= 0) begin
			cache_mac[match_slot] = r.mac_addr;
			a.learn_status        = LS_UPDATED;
		end else if (free_slot >= 0) begin
			cache_valid[free_slot] = 1'b1;
			cache_ip[free_slot]    = r.ip_addr;
			cache_mac[free_slot]   = r.mac_addr;
			a.learn_status         = LS_INSERTED;
		end else begin
			a.learn_status = LS_FULL;
		end
		return a;
	endfunction

	task automatic add_request(logic kind, logic [31:0] ip, logic [47:0] mac);
		req_t r;
		r.req_type = kind;
		r.ip_addr  = ip;
		r.mac_addr = mac;
		request_q.push_back(r);
		queued_count++;
	endtask

	// Random request: mostly addresses from the pool so lookups hit and learns update
	task automatic add_random_request();
		logic [31:0] ip;
		ip = roll(80) ? ip_pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
		add_request(roll(40) ? REQ_LEARN : REQ_LOOKUP, ip, rand_mac());
	endtask

	// Request driver: advance on acceptance, idle at random
	always @(negedge clk) begin
		if (arst_n && (!req_valid || req_taken)) begin
			if (request_q.size() != 0 && !roll(send_idle_pct)) begin
				req       <= request_q.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Response stall: long hold-off once armed, random stalls otherwise
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_armed && !hold_started) begin
				hold_started <= 1'b1;
				hold_left    <= HOLD_CYCLES;
				rsp_stall    <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= roll(stall_pct);
			end
		end
	end

	// Monitor: predict on request acceptance, check each accepted response
	always @(posedge clk) begin
		rsp_t want;
		req_taken <= req_valid && !req_stall;
		if (arst_n && req_valid && !req_stall) begin
			answer_q.push_back(resolve_request(req));
			accepted_count <= accepted_count + 1;
		end
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (answer_q.size() == 0) begin
				$error("response with nothing expected: hit %0b mac_out %h status %0d",
					rsp.hit, rsp.mac_out, rsp.learn_status);
				fail_count++;
			end else begin
				want = answer_q.pop_front();
				if (rsp.hit !== want.hit) begin
					$error("hit: expected %0b actual %0b", want.hit, rsp.hit);
					fail_count++;
				end
				if (rsp.mac_out !== want.mac_out) begin
					$error("mac_out: expected %h actual %h", want.mac_out, rsp.mac_out);
					fail_count++;
				end
				if (rsp.learn_status !== want.learn_status) begin
					$error("learn_status: expected %0d actual %0d",
						want.learn_status, rsp.learn_status);
					fail_count++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Stimulus and end of run
	initial begin
		for (int k = 0; k < TABLE_ENTRIES; k++) begin
			cache_valid[k] = 1'b0;
			cache_ip[k]    = '0;
			cache_mac[k]   = '0;
		end
		for (int k = 0; k < POOL_SIZE; k++)
			ip_pool[k] = $urandom;
		ip_pool[0] = 32'h0000_0000;
		ip_pool[1] = 32'hffff_ffff;

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Directed: empty-table misses, extremes, updates, ignored mac on lookup
		add_request(REQ_LOOKUP, 32'h0000_0000, 48'h0000_0000_0000);
		add_request(REQ_LOOKUP, 32'hffff_ffff, 48'hffff_ffff_ffff);
		add_request(REQ_LEARN,  32'h0000_0000, 48'h0000_0000_0000);
		add_request(REQ_LEARN,  32'hffff_ffff, 48'hffff_ffff_ffff);
		add_request(REQ_LOOKUP, 32'h0000_0000, 48'hffff_ffff_ffff);
		add_request(REQ_LOOKUP, 32'hffff_ffff, 48'h0000_0000_0000);
		add_request(REQ_LEARN,  32'h0000_0000, 48'haaaa_aaaa_aaaa);
		add_request(REQ_LOOKUP, 32'h0000_0000, 48'h0000_0000_0000);
		add_request(REQ_LOOKUP, 32'h0000_0001, 48'h0000_0000_0000);
		add_request(REQ_LEARN,  32'h8000_0000, 48'h8000_0000_0000);
		add_request(REQ_LOOKUP, 32'h7fff_ffff, 48'h0000_0000_0000);
		add_request(REQ_LOOKUP, 32'h8000_0000, 48'h0000_0000_0000);
		add_request(REQ_LEARN,  32'hffff_ffff, 48'h0000_0000_0000);
		add_request(REQ_LOOKUP, 32'hffff_ffff, 48'h5555_5555_5555);
		add_request(REQ_LEARN,  32'hc0a8_0001, 48'h0123_4567_89ab);
		add_request(REQ_LOOKUP, 32'hc0a8_0001, 48'h5555_5555_5555);
		add_request(REQ_LEARN,  32'h0000_0001, 48'h0000_0000_0001);
		add_request(REQ_LOOKUP, 32'h0000_0001, 48'h0000_0000_0000);
		add_request(REQ_LOOKUP, 32'hfffe_ffff, 48'h0000_0000_0000);
		wait (accepted_count == queued_count);

		// Random phases: no idling, sender idle, receiver stall, both, then hold-off
		for (int p = 0; p < 5; p++) begin
			case (p)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 63; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 63; end
				3: begin send_idle_pct = 22; stall_pct = 22; end
				default: begin
					send_idle_pct = 0;
					stall_pct     = 22;
					hold_armed    = 1'b1;
				end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++)
				add_random_request();
			wait (accepted_count == queued_count);
		end

		// Drain outstanding responses, then let the block settle
		wait (answer_q.size() == 0);
		repeat (TABLE_ENTRIES + 8) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
